/* hw/rtl/dms_pkg.sv */
// Shared constants, types and the quarter-wave sine table of the DFT magnitude spectrum.
package dms_pkg;

	localparam int POINTS     = 64;
	localparam int PT_W       = $clog2(POINTS);
	localparam int SAMPLE_W   = 16;
	localparam int TW_W       = 16;
	localparam int PROD_W     = SAMPLE_W + TW_W;
	localparam int ACC_W      = PROD_W + PT_W;
	localparam int PART_W     = ACC_W - 1 - PT_W;
	localparam int SQ_W       = 2 * PART_W + 1;
	localparam int ROOT_W     = (SQ_W + 1) / 2;
	localparam int MAG_W      = 16;
	localparam int BIN_W      = 6;
	localparam int END_W      = 7;
	localparam int TAB_IDX_W  = PT_W + 1;
	localparam logic [63:0] PIHALF_Q30 = 64'd1686629713;

	typedef logic [TW_W-1:0] qsin_tab_t [0:POINTS];

	// Quarter-wave sine in Q15, odd Taylor series through x^11 worked in Q30.
	function automatic qsin_tab_t build_qsin();
		qsin_tab_t   tab;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		longint      acc;
		for (int m = 0; m <= POINTS; m++) begin
			x    = (PIHALF_Q30 * 64'(m)) / 64'(POINTS);
			x2   = (x * x) >> 30;
			term = x;
			acc  = longint'(x);
			term = ((term * x2) >> 30) / 64'd6;
			acc  = acc - longint'(term);
			term = ((term * x2) >> 30) / 64'd20;
			acc  = acc + longint'(term);
			term = ((term * x2) >> 30) / 64'd42;
			acc  = acc - longint'(term);
			term = ((term * x2) >> 30) / 64'd72;
			acc  = acc + longint'(term);
			term = ((term * x2) >> 30) / 64'd110;
			acc  = acc - longint'(term);
			if (acc < 0) begin
				acc = 0;
			end
			acc = (acc + 16384) >>> 15;
			if (acc > 32767) begin
				acc = 32767;
			end
			tab[m] = acc[TW_W-1:0];
		end
		return tab;
	endfunction

	localparam qsin_tab_t QSIN = build_qsin();

endpackage

/* hw/rtl/dft_magnitude_spectrum.sv */
// Top level of the direct DFT magnitude spectrum: sample ring, shared MAC, square root, ports.
// A frame is 64 sample beats, taken one per cycle while the block is loading; no sample is taken
// while a spectrum is being computed. Each bin from start_bin up to end_bin (exclusive, capped
// at 64) then goes through these steps: the ring of sample cells turns once past the single
// shared multiply-accumulate unit, the pipeline drains, absolute value, squaring and summing
// follow, the block waits on the one-bit-per-cycle square root, and the output register is
// loaded, the block waiting in that step while the output is stalled. Each bin leaves as one
// output beat carrying 2*|X[k]|/64 saturated to 65535, the bin index and a last flag on the
// final bin. An empty range emits nothing and the block goes straight back to loading.
// Registers are start_bin at byte address 0 and end_bin at byte address 4; the values present
// when the 64th sample is accepted govern that frame.
module dft_magnitude_spectrum
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [2:0]                  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [dms_pkg::SAMPLE_W-1:0] sample,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [dms_pkg::MAG_W-1:0]   magnitude,
	output logic [dms_pkg::BIN_W-1:0]   bin_index,
	output logic                        last_bin
);
	import dms_pkg::*;

	localparam logic REG_START = 1'b0;
	localparam logic REG_END   = 1'b1;

	typedef enum logic [2:0] {
		ST_LOAD, ST_RUN, ST_DRAIN, ST_ABS, ST_SQR, ST_SUM, ST_ROOT, ST_EMIT
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [BIN_W-1:0] start_bin_q;
	logic [END_W-1:0] end_bin_q;
	logic             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_bin_q <= '0;
			end_bin_q   <= END_W'(64);
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_START: start_bin_q <= pwdata[BIN_W-1:0];
				REG_END:   end_bin_q   <= pwdata[END_W-1:0];
				default:   ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_START: prdata = 32'(start_bin_q);
			REG_END:   prdata = 32'(end_bin_q);
			default:   prdata = '0;
		endcase
	end

	// Sample ring. Loading pushes samples in at the far end, so after a full frame the head
	// cell holds sample 0; during a bin the ring turns once and ends where it began.
	logic [SAMPLE_W-1:0] ring [0:POINTS-1];
	logic                ring_shift;
	logic                in_acc;

	assign in_ready   = (state_q == ST_LOAD);
	assign in_acc     = in_valid && in_ready;
	assign ring_shift = in_acc || (state_q == ST_RUN);

	for (genvar i = 0; i < POINTS; i++) begin : g_ring
		logic [SAMPLE_W-1:0] cell_d;
		if (i == POINTS - 1) begin : g_tail
			assign cell_d = (state_q == ST_LOAD) ? sample : ring[0];
		end else begin : g_mid
			assign cell_d = ring[i+1];
		end
		dms_cell u_cell (
			.clk   (clk),
			.shift (ring_shift),
			.d     (cell_d),
			.q     (ring[i])
		);
	end

	// Frame and bin control.
	logic [END_W-1:0] load_count_q;
	logic [BIN_W-1:0] k_q;
	logic [END_W-1:0] stop_q;
	logic [PT_W-1:0]  j_q;
	logic             acc_clr_q;
	logic [END_W-1:0] stop_now;
	logic [END_W-1:0] k_next;

	assign stop_now = (end_bin_q > END_W'(64)) ? END_W'(64) : end_bin_q;
	assign k_next   = END_W'(k_q) + END_W'(1);

	// Twiddle lookup for the current sample: r = k*j mod 64 folded into four quadrants.
	logic [2*PT_W-1:0]       kj;
	logic [PT_W-1:0]         r;
	logic [1:0]              quad;
	logic [TAB_IDX_W-1:0]    rem;
	logic signed [TW_W-1:0]  s_raw;
	logic signed [TW_W-1:0]  c_raw;
	logic signed [TW_W-1:0]  sn;
	logic signed [TW_W-1:0]  cs;

	assign kj    = (2*PT_W)'(k_q) * (2*PT_W)'(j_q);
	assign r     = kj[PT_W-1:0];
	assign quad  = r[PT_W-1 -: 2];
	assign rem   = {1'b0, r[PT_W-3:0], 2'b00};
	assign s_raw = QSIN[rem];
	assign c_raw = QSIN[TAB_IDX_W'(POINTS) - rem];

	always_comb begin
		case (quad)
			2'd0:    begin sn = s_raw;  cs = c_raw;  end
			2'd1:    begin sn = c_raw;  cs = -s_raw; end
			2'd2:    begin sn = -s_raw; cs = -c_raw; end
			default: begin sn = -c_raw; cs = s_raw;  end
		endcase
	end

	// Multiply-accumulate pipeline: operands, products, accumulate.
	logic                       v_s1;
	logic signed [SAMPLE_W-1:0] samp_s1;
	logic signed [TW_W-1:0]     sn_s1;
	logic signed [TW_W-1:0]     cs_s1;
	logic                       v_s2;
	logic signed [PROD_W-1:0]   pre_s2;
	logic signed [PROD_W-1:0]   pim_s2;
	logic signed [ACC_W-1:0]    acc_re_q;
	logic signed [ACC_W-1:0]    acc_im_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_RUN);
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		samp_s1 <= ring[0];
		sn_s1   <= sn;
		cs_s1   <= cs;
		pre_s2  <= samp_s1 * cs_s1;
		pim_s2  <= samp_s1 * sn_s1;
		if (acc_clr_q) begin
			acc_re_q <= '0;
			acc_im_q <= '0;
		end else if (v_s2) begin
			acc_re_q <= acc_re_q + ACC_W'(pre_s2);
			acc_im_q <= acc_im_q + ACC_W'(pim_s2);
		end
	end

	// Magnitude: |sum| / 64, squares, and their sum into the square root.
	logic [ACC_W-1:0]  abs_re;
	logic [ACC_W-1:0]  abs_im;
	logic [PART_W-1:0] a_q;
	logic [PART_W-1:0] b_q;
	logic [SQ_W-1:0]   aa_q;
	logic [SQ_W-1:0]   bb_q;
	logic [SQ_W-1:0]   sq_sum_q;
	logic              sqrt_start_q;
	logic              sqrt_done;
	logic [ROOT_W-1:0] root;
	logic [ROOT_W-1:0] root_sh;

	assign abs_re  = acc_re_q[ACC_W-1] ? ACC_W'(-acc_re_q) : ACC_W'(acc_re_q);
	assign abs_im  = acc_im_q[ACC_W-1] ? ACC_W'(-acc_im_q) : ACC_W'(acc_im_q);
	assign root_sh = root >> 14;

	always_ff @(posedge clk) begin
		a_q      <= abs_re[PT_W +: PART_W];
		b_q      <= abs_im[PT_W +: PART_W];
		aa_q     <= SQ_W'(a_q) * SQ_W'(a_q);
		bb_q     <= SQ_W'(b_q) * SQ_W'(b_q);
		sq_sum_q <= aa_q + bb_q;
	end

	dms_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start_q),
		.value  (sq_sum_q),
		.done   (sqrt_done),
		.root   (root)
	);

	// Output register and sequencer.
	logic             out_valid_q;
	logic [MAG_W-1:0] magnitude_q;
	logic [BIN_W-1:0] bin_index_q;
	logic             last_bin_q;
	logic [MAG_W-1:0] mag_sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_LOAD;
			load_count_q <= '0;
			k_q          <= '0;
			stop_q       <= '0;
			j_q          <= '0;
			acc_clr_q    <= 1'b0;
			sqrt_start_q <= 1'b0;
			out_valid_q  <= 1'b0;
			magnitude_q  <= '0;
			bin_index_q  <= '0;
			last_bin_q   <= 1'b0;
			mag_sat_q    <= '0;
		end else begin
			acc_clr_q    <= 1'b0;
			sqrt_start_q <= 1'b0;
			// In the emit state the output register is handled below, so a beat taken there
			// is replaced by the next one in the same cycle.
			if (out_valid_q && out_ready && state_q != ST_EMIT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (load_count_q == END_W'(POINTS - 1)) begin
							load_count_q <= '0;
							k_q          <= start_bin_q;
							stop_q       <= stop_now;
							j_q          <= '0;
							if (stop_now > END_W'(start_bin_q)) begin
								acc_clr_q <= 1'b1;
								state_q   <= ST_RUN;
							end
						end else begin
							load_count_q <= load_count_q + END_W'(1);
						end
					end
				end
				ST_RUN: begin
					j_q <= j_q + PT_W'(1);
					if (j_q == PT_W'(POINTS - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!v_s1 && !v_s2) begin
						state_q <= ST_ABS;
					end
				end
				ST_ABS: state_q <= ST_SQR;
				ST_SQR: state_q <= ST_SUM;
				ST_SUM: begin
					sqrt_start_q <= 1'b1;
					state_q      <= ST_ROOT;
				end
				ST_ROOT: begin
					if (sqrt_done) begin
						mag_sat_q <= (root_sh > ROOT_W'(65535)) ? MAG_W'(65535)
						                                        : root_sh[MAG_W-1:0];
						state_q   <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						magnitude_q <= mag_sat_q;
						bin_index_q <= k_q;
						last_bin_q  <= (k_next == stop_q);
						if (k_next == stop_q) begin
							state_q <= ST_LOAD;
						end else begin
							k_q       <= k_next[BIN_W-1:0];
							j_q       <= '0;
							acc_clr_q <= 1'b1;
							state_q   <= ST_RUN;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign magnitude = magnitude_q;
	assign bin_index = bin_index_q;
	assign last_bin  = last_bin_q;

endmodule

/* hw/rtl/dms_cell.sv */
// One cell of the sample ring: holds a sample and passes it on when the ring moves.
module dms_cell
(
	input  logic                         clk,
	input  logic                         shift,
	input  logic [dms_pkg::SAMPLE_W-1:0] d,
	output logic [dms_pkg::SAMPLE_W-1:0] q
);
	import dms_pkg::*;

	logic [SAMPLE_W-1:0] data_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			data_q <= d;
		end
	end

	assign q = data_q;

endmodule

/* hw/rtl/dms_isqrt.sv */
// Bit-pair integer square root, one result bit per clock.
module dms_isqrt
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [dms_pkg::SQ_W-1:0]   value,
	output logic                       done,
	output logic [dms_pkg::ROOT_W-1:0] root
);
	import dms_pkg::*;

	localparam logic [SQ_W-1:0] TOP_BIT = SQ_W'(1) << (2 * (ROOT_W - 1));

	logic [SQ_W-1:0] rem_q;
	logic [SQ_W-1:0] res_q;
	logic [SQ_W-1:0] bit_q;
	logic            busy_q;
	logic            done_q;
	logic [SQ_W-1:0] trial;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q == SQ_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= value;
			res_q <= '0;
			bit_q <= TOP_BIT;
		end else if (busy_q) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[ROOT_W-1:0];

endmodule

/* test/dft_magnitude_spectrum_tb.sv */
// Self-checking testbench for the DFT magnitude spectrum: frames, bin ranges, stalls and predictor.
module dft_magnitude_spectrum_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dms_pkg::*;

	// Register byte addresses on the configuration port.
	localparam logic [2:0] ADDR_START_BIN = 3'd0;
	localparam logic [2:0] ADDR_END_BIN   = 3'd4;
	localparam int         FRAME_LEN      = 64;
	localparam int         NUM_FRAMES     = 7;
	localparam int         CYCLE_LIMIT    = 600000;
	localparam int         DRAIN_CYCLES   = 250;
	localparam int         LONG_HOLD      = 3000;

	// Expected result of one bin.
	typedef struct packed {
		logic [MAG_W-1:0] mag;
		logic [BIN_W-1:0] bin;
		logic             last;
	} bin_result_t;

	// Spectrum predictor and store of bins still owed by the block.
	class spectrum_board;
		bin_result_t   owed[$];
		int            mismatches;
		int            bins_checked;
		int            frames_done;
		logic [5:0]    first_bin;
		logic [6:0]    stop_bin;
		logic [15:0]   frame_buf[FRAME_LEN];
		int            fill;
		longint        quarter_wave[FRAME_LEN + 1];

		function new();
			bit [63:0] x, x2, term;
			longint    acc;
			first_bin = 6'd0;
			stop_bin  = 7'd64;
			fill      = 0;
			for (int m = 0; m <= FRAME_LEN; m++) begin
				x    = (64'd1686629713 * 64'(m)) / 64'(FRAME_LEN);
				x2   = (x * x) >> 30;
				term = x;
				acc  = longint'(x);
				for (int n = 1; n <= 5; n++) begin
					term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
					if (n % 2 == 1) begin
						acc -= longint'(term);
					end else begin
						acc += longint'(term);
					end
				end
				if (acc < 0) begin
					acc = 0;
				end
				acc = (acc + 16384) / 32768;
				quarter_wave[m] = (acc > 32767) ? 32767 : acc;
			end
		endfunction

		function void set_register(logic [2:0] addr, logic [31:0] value);
			if (addr == ADDR_START_BIN) begin
				first_bin = value[5:0];
			end else if (addr == ADDR_END_BIN) begin
				stop_bin = value[6:0];
			end
		endfunction

		function bit [63:0] int_sqrt(bit [63:0] v);
			bit [63:0] res, bitv;
			res  = 0;
			bitv = 64'd1 << 62;
			while (bitv > v) begin
				bitv >>= 2;
			end
			while (bitv != 0) begin
				if (v >= res + bitv) begin
					v   = v - (res + bitv);
					res = (res >> 1) + bitv;
				end else begin
					res >>= 1;
				end
				bitv >>= 2;
			end
			return res;
		endfunction

		// Stores one accepted sample; a full frame produces its bins.
		function void note_sample(logic [15:0] s);
			int          stop, r, q, rem;
			longint      sn, cs, re, im, smp;
			bit [63:0]   a, b, root;
			bin_result_t exp_bin;
			frame_buf[fill] = s;
			fill++;
			if (fill < FRAME_LEN) begin
				return;
			end
			fill = 0;
			frames_done++;
			stop = (stop_bin > 64) ? 64 : int'(stop_bin);
			for (int k = first_bin; k < stop; k++) begin
				re = 0;
				im = 0;
				for (int j = 0; j < FRAME_LEN; j++) begin
					r   = (k * j) % FRAME_LEN;
					q   = (4 * r) / FRAME_LEN;
					rem = 4 * r - q * FRAME_LEN;
					case (q)
						0: begin sn = quarter_wave[rem]; cs = quarter_wave[FRAME_LEN - rem]; end
						1: begin sn = quarter_wave[FRAME_LEN - rem]; cs = -quarter_wave[rem]; end
						2: begin sn = -quarter_wave[rem]; cs = -quarter_wave[FRAME_LEN - rem]; end
						default: begin
							sn = -quarter_wave[FRAME_LEN - rem];
							cs = quarter_wave[rem];
						end
					endcase
					smp = longint'($signed(frame_buf[j]));
					re += smp * cs;
					im -= smp * sn;
				end
				a    = 64'((re < 0) ? -re : re) / FRAME_LEN;
				b    = 64'((im < 0) ? -im : im) / FRAME_LEN;
				root = int_sqrt(a * a + b * b) >> 14;
				exp_bin.mag  = (root > 65535) ? 16'hFFFF : root[15:0];
				exp_bin.bin  = k[5:0];
				exp_bin.last = (k + 1 == stop);
				owed.push_back(exp_bin);
			end
		endfunction

		function void check(logic [15:0] mag, logic [5:0] bin, logic last);
			bin_result_t want;
			bins_checked++;
			if (owed.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected bin beat: mag=%0d bin=%0d last=%0b", mag, bin, last);
				end
				return;
			end
			want = owed.pop_front();
			if (want.mag !== mag || want.bin !== bin || want.last !== last) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("bin mismatch: expected mag=%0d bin=%0d last=%0b, got mag=%0d bin=%0d last=%0b",
						want.mag, want.bin, want.last, mag, bin, last);
				end
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                psel, penable, pwrite, pready;
	logic [2:0]          paddr;
	logic [31:0]         pwdata, prdata;
	logic                in_valid, in_ready;
	logic [SAMPLE_W-1:0] sample;
	logic                out_valid, out_ready;
	logic [MAG_W-1:0]    magnitude;
	logic [BIN_W-1:0]    bin_index;
	logic                last_bin;

	spectrum_board sb = new();

	int send_idle_pct = 22;
	int recv_idle_pct = 81;
	bit hold_request  = 1'b0;
	int hold_left     = 0;
	int cycle_count   = 0;

	dft_magnitude_spectrum uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .sample(sample),
		.out_valid(out_valid), .out_ready(out_ready),
		.magnitude(magnitude), .bin_index(bin_index), .last_bin(last_bin)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog: the slowest legal run is well under this limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Receiver: random back-pressure, plus one long hold-off counted here in cycles.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Every bin beat taken by the receiver is compared with the oldest expected bin.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			sb.check(magnitude, bin_index, last_bin);
		end
	end

	// Register write with a setup phase and then an access phase; the model is updated once the access cycle has passed.
	task automatic write_register(logic [2:0] addr, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		sb.set_register(addr, value);
	endtask

	// Offers one sample beat, with random gaps first, and holds it until accepted.
	task automatic send_sample(logic [15:0] s);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		sample   <= s;
		do begin
			@(posedge clk);
		end while (!in_ready);
		sb.note_sample(s);
		@(negedge clk);
	endtask

	// Pauses the sender until every owed bin has come back, then lets the block settle.
	task automatic wait_spectrum_done();
		in_valid <= 1'b0;
		while (sb.owed.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin
		int          starts[NUM_FRAMES] = '{0, 63, 5, 0, 0, 20, 0};
		int          stops[NUM_FRAMES]  = '{64, 64, 5, 127, 127, 40, 0};
		logic [15:0] s;

		arst_n   = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		in_valid = 1'b0;
		sample   = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// The last frame uses a random bin range.
		starts[NUM_FRAMES-1] = $urandom_range(63);
		stops[NUM_FRAMES-1]  = $urandom_range(64);

		for (int f = 0; f < NUM_FRAMES; f++) begin
			// Idling pattern: receiver lazy first, then sender lazy, then full speed.
			if (f < 3) begin
				send_idle_pct = 22;
				recv_idle_pct = 81;
			end else if (f < 5) begin
				send_idle_pct = 81;
				recv_idle_pct = 22;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			// Frame four reuses frame three's range so the sender keeps pushing while
			// the receiver is held off and the block backs up.
			if (f != 4) begin
				wait_spectrum_done();
				write_register(ADDR_START_BIN, 32'(starts[f]));
				write_register(ADDR_END_BIN, 32'(stops[f]));
			end
			if (f == 3) begin
				hold_request = 1'b1;
			end
			for (int j = 0; j < FRAME_LEN; j++) begin
				if (f == 0) begin
					// Full-scale extremes: drives a strong Nyquist bin and covers both rails.
					case (j % 4)
						0: s = 16'sh7FFF;
						1: s = 16'sh8000;
						2: s = 16'h0000;
						default: s = 16'hFFFF;
					endcase
				end else if (f == 5) begin
					// Small amplitudes exercise the low end of the square root.
					s = 16'($signed($urandom_range(64)) - 32);
				end else begin
					s = 16'($urandom);
				end
				send_sample(s);
			end
		end
		in_valid <= 1'b0;

		while (sb.owed.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d frames, %0d bin beats: full, single, empty, capped and random ranges,",
			sb.frames_done, sb.bins_checked);
		$display("with sender and receiver stalls, a long output hold-off and %0d mismatches.",
			sb.mismatches);
		if (sb.mismatches == 0 && sb.owed.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule

/* sim.f */
hw/rtl/dms_pkg.sv
hw/rtl/dms_cell.sv
hw/rtl/dms_isqrt.sv
hw/rtl/dft_magnitude_spectrum.sv
test/dft_magnitude_spectrum_tb.sv
